### rtl/amou_pkg.sv
package amou_pkg;

   localparam int OP_W   = 4;
   localparam int ADDR_W = 10;
   localparam int DATA_W = 32;
   localparam int DEST_W = 5;

   typedef enum logic [OP_W-1:0] {
      OP_LR   = 4'd0,
      OP_SC   = 4'd1,
      OP_SWAP = 4'd2,
      OP_ADD  = 4'd3,
      OP_XOR  = 4'd4,
      OP_AND  = 4'd5,
      OP_OR   = 4'd6,
      OP_MIN  = 4'd7,
      OP_MAX  = 4'd8,
      OP_MINU = 4'd9,
      OP_MAXU = 4'd10
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic rem_step;
      logic rd_en;
      logic exec;
      logic clr_en;
   } dp_cmd_type;

   localparam logic [DATA_W-1:0] SC_PASS = 32'd0;
   localparam logic [DATA_W-1:0] SC_FAIL = 32'd1;

endpackage

### rtl/amou_ctrl.sv
module amou_ctrl
   import amou_pkg::*;
#(
   parameter int MEM_WORDS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   output logic                         rsp_strobe,
   output dp_cmd_type                   cmd,
   output logic [$clog2(MEM_WORDS)-1:0] clr_addr
);

   localparam int IDX_W  = $clog2(MEM_WORDS);
   // The address needs folding only when it can reach past the memory.
   localparam bit REDUCE = (MEM_WORDS < (1 << ADDR_W));

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_REDUCE,
      S_READ,
      S_EXEC
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic                busy_ff, busy_in;
   logic                strobe_ff, strobe_in;

   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == IDX_W'(MEM_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = REDUCE ? S_REDUCE : S_READ;
            end
         end
         S_REDUCE: begin
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      busy_in   = (state_in != S_IDLE);
      strobe_in = (state_ff == S_EXEC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_cnt_ff  <= '0;
         busy_ff     <= 1'b1;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         busy_ff     <= busy_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_comb begin
      cmd.load     = (state_ff == S_IDLE) && start;
      cmd.rem_step = (state_ff == S_REDUCE);
      cmd.rd_en    = (state_ff == S_READ);
      cmd.exec     = (state_ff == S_EXEC);
      cmd.clr_en   = (state_ff == S_CLEAR);
   end

   assign clr_addr   = clr_cnt_ff;
   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

### rtl/amou_datapath.sv
module amou_datapath
   import amou_pkg::*;
#(
   parameter int MEM_WORDS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   input  logic [$clog2(MEM_WORDS)-1:0] clr_addr,
   input  logic [OP_W-1:0]              req_type,
   input  logic [ADDR_W-1:0]            req_word_addr,
   input  logic [DATA_W-1:0]            req_operand,
   input  logic [DEST_W-1:0]            req_dest_index,
   output logic [DATA_W-1:0]            rsp_rd_value,
   output logic [DEST_W-1:0]            rsp_write_index
);

   localparam int IDX_W   = $clog2(MEM_WORDS);
   localparam int FOLD_SH = ADDR_W + IDX_W;
   localparam int RECIP_W = ADDR_W + 2;
   localparam int PROD_W  = ADDR_W + RECIP_W;
   localparam int RECIP   = ((1 << FOLD_SH) + MEM_WORDS - 1) / MEM_WORDS;
   localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
   localparam logic [ADDR_W-1:0]  DIVISOR = ADDR_W'(MEM_WORDS);

   logic [DATA_W-1:0] mem [MEM_WORDS];

   op_type            op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] quot_ff, quot_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [DATA_W-1:0] operand_ff;
   logic [DEST_W-1:0] dest_ff;
   logic [DATA_W-1:0] rdata_ff;
   logic              res_valid_ff, res_valid_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [DATA_W-1:0] rd_value_ff, rd_value_in;
   logic [DEST_W-1:0] windex_ff;

   logic [PROD_W-1:0] prod;
   logic [IDX_W-1:0]  idx;
   logic [IDX_W-1:0]  waddr;
   logic [DATA_W-1:0] wdata;
   logic [DATA_W-1:0] new_word;
   logic              write_ok;
   logic              we;
   logic              sc_ok;
   logic              src_lt_s;
   logic              src_lt_u;

   // The quotient by MEM_WORDS comes from a reciprocal multiplication that is
   // exact for every ADDR_W-bit address; the fold step then subtracts the
   // quotient times MEM_WORDS. A memory that covers every address skips it.
   always_comb begin
      prod    = req_word_addr * RECIP_V;
      quot_in = quot_ff;
      idx_in  = idx_ff;
      if (cmd.load) begin
         quot_in = ADDR_W'(prod >> FOLD_SH);
         idx_in  = IDX_W'(req_word_addr);
      end else if (cmd.rem_step) begin
         idx_in = IDX_W'(addr_ff - quot_ff * DIVISOR);
      end
   end

   assign idx = idx_ff;

   always_comb begin
      sc_ok    = res_valid_ff && (res_addr_ff == addr_ff);
      src_lt_s = $signed(operand_ff) < $signed(rdata_ff);
      src_lt_u = operand_ff < rdata_ff;
      new_word     = rdata_ff;
      write_ok     = 1'b1;
      rd_value_in  = rdata_ff;
      res_valid_in = res_valid_ff;
      res_addr_in  = res_addr_ff;
      unique case (op_ff)
         OP_LR: begin
            write_ok     = 1'b0;
            res_valid_in = 1'b1;
            res_addr_in  = addr_ff;
         end
         OP_SC: begin
            new_word     = operand_ff;
            write_ok     = sc_ok;
            rd_value_in  = sc_ok ? SC_PASS : SC_FAIL;
            res_valid_in = 1'b0;
            res_addr_in  = '0;
         end
         OP_SWAP: new_word = operand_ff;
         OP_ADD:  new_word = rdata_ff + operand_ff;
         OP_XOR:  new_word = rdata_ff ^ operand_ff;
         OP_AND:  new_word = rdata_ff & operand_ff;
         OP_OR:   new_word = rdata_ff | operand_ff;
         OP_MIN:  new_word = src_lt_s ? operand_ff : rdata_ff;
         OP_MAX:  new_word = src_lt_s ? rdata_ff : operand_ff;
         OP_MINU: new_word = src_lt_u ? operand_ff : rdata_ff;
         OP_MAXU: new_word = src_lt_u ? rdata_ff : operand_ff;
         default: begin
            // An unused operation code touches nothing and returns zero.
            write_ok    = 1'b0;
            rd_value_in = '0;
         end
      endcase
   end

   assign we    = cmd.clr_en || (cmd.exec && write_ok);
   assign waddr = cmd.clr_en ? clr_addr : idx;
   assign wdata = cmd.clr_en ? '0 : new_word;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
         res_addr_ff  <= '0;
      end else if (cmd.exec) begin
         res_valid_ff <= res_valid_in;
         res_addr_ff  <= res_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      idx_ff  <= idx_in;
      if (cmd.load) begin
         op_ff      <= op_type'(req_type);
         addr_ff    <= req_word_addr;
         operand_ff <= req_operand;
         dest_ff    <= req_dest_index;
      end
      if (cmd.exec) begin
         rd_value_ff <= rd_value_in;
         windex_ff   <= dest_ff;
      end
   end

   assign rsp_rd_value    = rd_value_ff;
   assign rsp_write_index = windex_ff;

endmodule

### rtl/atomic_memory_op_unit.sv
// Atomic memory operation unit: RV32A LR, SC and AMO operations on an
// internal memory of MEM_WORDS 32-bit words.
//
// Requests use a command handshake: an item is taken at a clock edge with
// start high and busy low, its fields on req_type, req_word_addr,
// req_operand and req_dest_index. Each item gives one result, shown on
// rsp_rd_value and rsp_write_index for exactly one cycle while rsp_strobe
// is high. The receiver cannot hold results back.
//
// The result strobe is registered from the execute state, and busy is
// already low in the cycle it is high, so a new item can be taken while
// the result is shown. The sequence is index, synchronous memory read, then
// combine and write back. When MEM_WORDS is below 1024 the address is
// folded into the memory by a reciprocal multiplication and a subtraction,
// which adds a reduce state ahead of the read.
//
// After reset the unit clears the memory one word per cycle with busy
// high, and drops any reservation.
module atomic_memory_op_unit
   import amou_pkg::*;
#(
   parameter int MEM_WORDS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_type,
   input  logic [ADDR_W-1:0] req_word_addr,
   input  logic [DATA_W-1:0] req_operand,
   input  logic [DEST_W-1:0] req_dest_index,
   output logic              rsp_strobe,
   output logic [DATA_W-1:0] rsp_rd_value,
   output logic [DEST_W-1:0] rsp_write_index
);

   dp_cmd_type                   cmd;
   logic [$clog2(MEM_WORDS)-1:0] clr_addr;

   amou_ctrl #(
      .MEM_WORDS (MEM_WORDS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .clr_addr   (clr_addr)
   );

   amou_datapath #(
      .MEM_WORDS (MEM_WORDS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .clr_addr        (clr_addr),
      .req_type        (req_type),
      .req_word_addr   (req_word_addr),
      .req_operand     (req_operand),
      .req_dest_index  (req_dest_index),
      .rsp_rd_value    (rsp_rd_value),
      .rsp_write_index (rsp_write_index)
   );

endmodule

### rtl/amou_checker.sv
module amou_checker
   import amou_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input logic [DATA_W-1:0] rsp_rd_value,
   input logic [DEST_W-1:0] rsp_write_index
);

   logic accept;
   assign accept = start && !busy;

   // A taken item occupies the unit until its result is out.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy low right after an item was taken");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp_strobe)
      else $error("result shown in the cycle after an item was taken");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // A result only ends a stretch of work and leaves the unit free.
   a_strobe_ends_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result strobe without a preceding busy cycle");

   a_result_known: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$isunknown({rsp_rd_value, rsp_write_index}))
      else $error("result fields unknown while the strobe is high");

endmodule

bind atomic_memory_op_unit amou_checker u_amou_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_rd_value    (rsp_rd_value),
   .rsp_write_index (rsp_write_index)
);

### test/tb_atomic_memory_op_unit.sv
module tb_atomic_memory_op_unit;
   import amou_pkg::*;

   localparam int MEM_DEPTH = 1024;
   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEMS_PER_PHASE = 238;
   localparam int DRAIN_CYCLES = 12;
   localparam int NUM_DIRECTED = 25;

   // Operation codes that the unit does not define.
   localparam logic [OP_W-1:0] OP_RSVD_LO = 4'd11;
   localparam logic [OP_W-1:0] OP_RSVD_HI = 4'd15;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] val;
      logic [DEST_W-1:0] dst;
      logic              fixed;
      logic [DATA_W-1:0] rd;
   } directed_row_type;

   typedef struct {
      logic [DATA_W-1:0] rd;
      logic [DEST_W-1:0] idx;
   } owed_result_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [OP_W-1:0]   req_type;
   logic [ADDR_W-1:0] req_word_addr;
   logic [DATA_W-1:0] req_operand;
   logic [DEST_W-1:0] req_dest_index;
   logic              rsp_strobe;
   logic [DATA_W-1:0] rsp_rd_value;
   logic [DEST_W-1:0] rsp_write_index;

   // Sideband that travels with the item on the request ports.
   logic              req_fixed;
   logic [DATA_W-1:0] req_fixed_rd;

   logic [DATA_W-1:0] model_words [MEM_DEPTH];
   logic [ADDR_W-1:0] model_resv_addr;
   logic              model_resv_valid;

   owed_result_type   owed_results[$];
   directed_row_type  directed [NUM_DIRECTED];
   int                idle_pct;
   int                fail_count;
   int                cycles;

   atomic_memory_op_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_word_addr   (req_word_addr),
      .req_operand     (req_operand),
      .req_dest_index  (req_dest_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_rd_value    (rsp_rd_value),
      .rsp_write_index (rsp_write_index)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Applies one atomic operation to the memory image and returns rd.
   task automatic apply_atomic_op(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                  input logic [DATA_W-1:0] val,
                                  output logic [DATA_W-1:0] rd);
      logic [DATA_W-1:0] old;
      int                slot;
      slot = addr % MEM_DEPTH;
      old = model_words[slot];
      rd = old;
      case (op)
         OP_LR: begin
            model_resv_addr = addr;
            model_resv_valid = 1'b1;
         end
         OP_SC: begin
            if (model_resv_valid && model_resv_addr == addr) begin
               model_words[slot] = val;
               rd = SC_PASS;
            end else begin
               rd = SC_FAIL;
            end
            model_resv_valid = 1'b0;
            model_resv_addr = '0;
         end
         OP_SWAP: model_words[slot] = val;
         OP_ADD:  model_words[slot] = old + val;
         OP_XOR:  model_words[slot] = old ^ val;
         OP_AND:  model_words[slot] = old & val;
         OP_OR:   model_words[slot] = old | val;
         OP_MIN:  model_words[slot] = ($signed(val) < $signed(old)) ? val : old;
         OP_MAX:  model_words[slot] = ($signed(old) < $signed(val)) ? val : old;
         OP_MINU: model_words[slot] = (val < old) ? val : old;
         OP_MAXU: model_words[slot] = (old < val) ? val : old;
         default: rd = '0;
      endcase
   endtask

   always @(posedge clock) begin : result_check
      owed_result_type   want;
      logic [DATA_W-1:0] rd;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (owed_results.size() == 0) begin
               $error("unexpected result: rd_value %h write_index %0d",
                      rsp_rd_value, rsp_write_index);
               fail_count++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_rd_value !== want.rd) begin
                  $error("rd_value: expected %h, got %h", want.rd, rsp_rd_value);
                  fail_count++;
               end
               if (rsp_write_index !== want.idx) begin
                  $error("write_index: expected %0d, got %0d", want.idx, rsp_write_index);
                  fail_count++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            apply_atomic_op(req_type, req_word_addr, req_operand, rd);
            want.rd = req_fixed ? req_fixed_rd : rd;
            want.idx = req_dest_index;
            owed_results.push_back(want);
         end
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] val, input logic [DEST_W-1:0] dst,
                            input logic fixed, input logic [DATA_W-1:0] fixed_rd);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_type <= op;
      req_word_addr <= addr;
      req_operand <= val;
      req_dest_index <= dst;
      req_fixed <= fixed;
      req_fixed_rd <= fixed_rd;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Mostly a small pool of addresses, so that words and reservations get reused.
   function automatic logic [ADDR_W-1:0] pick_addr();
      if ($urandom_range(99) < 70) return ADDR_W'($urandom_range(15));
      return ADDR_W'($urandom_range(MEM_DEPTH - 1));
   endfunction

   function automatic logic [DATA_W-1:0] pick_operand();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_amo(input logic [ADDR_W-1:0] addr);
      send_item(OP_W'($urandom_range(OP_SWAP, OP_MAXU)), addr, pick_operand(),
                DEST_W'($urandom_range(31)), 1'b0, '0);
   endtask

   initial begin : stimulus
      int                pct [4];
      int                sent;
      int                gap;
      logic [ADDR_W-1:0] a;
      pct = '{0, 54, 0, 21};
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_type = '0;
      req_word_addr = '0;
      req_operand = '0;
      req_dest_index = '0;
      req_fixed = 1'b0;
      req_fixed_rd = '0;
      idle_pct = 0;
      fail_count = 0;
      cycles = 0;
      model_resv_addr = '0;
      model_resv_valid = 1'b0;
      for (int i = 0; i < MEM_DEPTH; i++) model_words[i] = '0;

      // Rows with fixed = 1 carry the value read straight off the spec.
      directed[0]  = '{OP_LR,   10'd0,    32'h0000_0000, 5'd0,  1'b1, 32'd0};
      directed[1]  = '{OP_SC,   10'd0,    32'hFFFF_FFFF, 5'd31, 1'b1, SC_PASS};
      directed[2]  = '{OP_SC,   10'd0,    32'h0000_0000, 5'd1,  1'b1, SC_FAIL};
      directed[3]  = '{OP_LR,   10'd1023, 32'h0000_0000, 5'd2,  1'b1, 32'd0};
      directed[4]  = '{OP_SWAP, 10'd1023, 32'h8000_0000, 5'd3,  1'b1, 32'd0};
      directed[5]  = '{OP_SC,   10'd1023, 32'h0000_0005, 5'd4,  1'b1, SC_PASS};
      directed[6]  = '{OP_ADD,  10'd1023, 32'hFFFF_FFFF, 5'd5,  1'b0, 32'd0};
      directed[7]  = '{OP_XOR,  10'd1023, 32'hAAAA_AAAA, 5'd6,  1'b0, 32'd0};
      directed[8]  = '{OP_AND,  10'd0,    32'h0F0F_0F0F, 5'd7,  1'b0, 32'd0};
      directed[9]  = '{OP_OR,   10'd0,    32'hF000_0000, 5'd8,  1'b0, 32'd0};
      directed[10] = '{OP_MIN,  10'd0,    32'h0000_0001, 5'd9,  1'b0, 32'd0};
      directed[11] = '{OP_MAX,  10'd0,    32'h7FFF_FFFF, 5'd10, 1'b0, 32'd0};
      directed[12] = '{OP_MIN,  10'd0,    32'h8000_0000, 5'd11, 1'b0, 32'd0};
      directed[13] = '{OP_MAXU, 10'd0,    32'hFFFF_FFFF, 5'd12, 1'b0, 32'd0};
      directed[14] = '{OP_MINU, 10'd0,    32'h0000_0000, 5'd13, 1'b0, 32'd0};
      directed[15] = '{OP_MAX,  10'd0,    32'h8000_0000, 5'd20, 1'b0, 32'd0};
      directed[16] = '{OP_MAXU, 10'd0,    32'h0000_0001, 5'd22, 1'b0, 32'd0};
      directed[17] = '{OP_RSVD_LO, 10'd0,    32'hFFFF_FFFF, 5'd21, 1'b1, 32'd0};
      directed[18] = '{OP_RSVD_HI, 10'd1023, 32'hFFFF_FFFF, 5'd31, 1'b1, 32'd0};
      directed[19] = '{OP_LR,   10'd4,    32'h0000_0000, 5'd14, 1'b1, 32'd0};
      directed[20] = '{OP_SC,   10'd5,    32'h0000_0001, 5'd15, 1'b1, SC_FAIL};
      directed[21] = '{OP_SC,   10'd4,    32'h0000_0001, 5'd16, 1'b1, SC_FAIL};
      directed[22] = '{OP_LR,   10'd4,    32'h0000_0000, 5'd17, 1'b1, 32'd0};
      directed[23] = '{OP_LR,   10'd7,    32'h0000_0000, 5'd18, 1'b1, 32'd0};
      directed[24] = '{OP_SC,   10'd4,    32'h0000_0001, 5'd19, 1'b1, SC_FAIL};

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_item(directed[i].op, directed[i].addr, directed[i].val, directed[i].dst,
                   directed[i].fixed, directed[i].rd);

      for (int p = 0; p < 4; p++) begin
         idle_pct = pct[p];
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            case ($urandom_range(99)) inside
               [0:44]: begin
                  // Reservation sequence: LR, up to two AMOs, then SC mostly on the same word.
                  a = pick_addr();
                  send_item(OP_LR, a, pick_operand(), DEST_W'($urandom_range(31)), 1'b0, '0);
                  gap = $urandom_range(2);
                  for (int k = 0; k < gap; k++)
                     send_amo(($urandom_range(1) == 0) ? a : pick_addr());
                  if ($urandom_range(99) >= 85) a = pick_addr();
                  send_item(OP_SC, a, pick_operand(), DEST_W'($urandom_range(31)), 1'b0, '0);
                  sent += gap + 2;
               end
               [45:89]: begin
                  send_amo(pick_addr());
                  sent++;
               end
               [90:93]: begin
                  send_item(OP_LR, pick_addr(), pick_operand(),
                            DEST_W'($urandom_range(31)), 1'b0, '0);
                  sent++;
               end
               [94:96]: begin
                  send_item(OP_SC, pick_addr(), pick_operand(),
                            DEST_W'($urandom_range(31)), 1'b0, '0);
                  sent++;
               end
               default: begin
                  send_item(OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), pick_addr(),
                            pick_operand(), DEST_W'($urandom_range(31)), 1'b0, '0);
                  sent++;
               end
            endcase
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
